// ===== rtl/bsc_pkg.sv =====
// shared calibration type, constants and helpers for the barometric compensation block
`timescale 1ns / 1ps
package bsc_pkg;
	localparam int unsigned CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] REG_CAL_A = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_CAL_B = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_CAL_C = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_CAL_D = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_CAL_E = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_OSS   = 3'd5;

	localparam logic [31:0] B6_OFFSET = 32'd4000;
	localparam logic [31:0] P_K1      = 32'd3038;
	localparam logic [31:0] P_K2      = 32'd7357;
	localparam logic [31:0] P_K3      = 32'd3791;
	localparam logic [31:0] B7_SCALE  = 32'd50000;
	localparam logic [31:0] B7_MSB    = 32'h8000_0000;
	localparam logic [31:0] B4_BIAS   = 32'd32768;

	// unpacked calibration set
	typedef struct packed {
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [1:0]  oss;
	} cal_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
		return 32'($signed(v) >>> s);
	endfunction
endpackage

// ===== rtl/bsc_div.sv =====
// pipelined restoring divider, one quotient bit per stage, 32-bit unsigned
`timescale 1ns / 1ps
module bsc_div import bsc_pkg::*; #(
	parameter int unsigned TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [31:0]      num,
	input  logic [31:0]      den,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_valid,
	output logic [31:0]      quo,
	output logic [TAG_W-1:0] out_tag
);
	logic [31:0]      rem_s  [1:32];
	logic [31:0]      num_s  [1:32];
	logic [31:0]      den_s  [1:32];
	logic [TAG_W-1:0] tag_s  [1:32];
	logic             vld_s  [1:32];

	for (genvar i = 0; i < 32; i++) begin : g_stage
		logic [31:0]      rem_in;
		logic [31:0]      num_in;
		logic [31:0]      den_in;
		logic [TAG_W-1:0] tag_in;
		logic             vld_in;
		logic [32:0]      trial;
		logic [32:0]      diff;
		// first stage takes the input word, later ones the previous stage
		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = num;
			assign den_in = den;
			assign tag_in = in_tag;
			assign vld_in = in_valid;
		end else begin : g_next
			assign rem_in = rem_s[i];
			assign num_in = num_s[i];
			assign den_in = den_s[i];
			assign tag_in = tag_s[i];
			assign vld_in = vld_s[i];
		end
		assign trial = {rem_in, num_in[31]};
		assign diff  = trial - {1'b0, den_in};
		// quotient bits shift into the low end of num
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_in;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= diff[32] ? trial[31:0] : diff[31:0];
				num_s[i+1] <= {num_in[30:0], ~diff[32]};
				den_s[i+1] <= den_in;
				tag_s[i+1] <= tag_in;
			end
		end
	end

	assign out_valid = vld_s[32];
	assign quo       = num_s[32];
	assign out_tag   = tag_s[32];
endmodule

// ===== rtl/bsc_temp.sv =====
// temperature path: x1, signed division by x1+md, b5 and temperature
`timescale 1ns / 1ps
module bsc_temp import bsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  cal_t        cal,
	input  logic [15:0] ut,
	input  logic [23:0] praw,
	output logic        out_valid,
	output logic [31:0] b5,
	output logic [31:0] temp,
	output logic        tfault,
	output logic [23:0] praw_o
);
	localparam int unsigned TW = 24 + 1 + 1 + 1 + 32;
	logic        v_s1;
	logic [31:0] prod_s1;
	logic [23:0] praw_s1;
	logic        v_s2;
	logic [31:0] x1_s2, den_s2;
	logic [23:0] praw_s2;
	logic [31:0] num, ad, an;
	logic        qneg, zero;
	logic [TW-1:0] tin, tout;
	logic [31:0] q;
	logic        dv;
	logic [31:0] x2, b5c;

	// stage 1: multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= ({16'd0, ut} - cal.ac6) * cal.ac5;
			praw_s1 <= praw;
			x1_s2   <= asr(prod_s1, 5'd15);
			den_s2  <= asr(prod_s1, 5'd15) + cal.md;
			praw_s2 <= praw_s1;
		end
	end

	// signed division by magnitudes
	assign num  = cal.mc << 11;
	assign an   = num[31] ? -num : num;
	assign ad   = den_s2[31] ? -den_s2 : den_s2;
	assign qneg = num[31] ^ den_s2[31];
	assign zero = (den_s2 == '0);
	assign tin  = {praw_s2, qneg, zero, 1'b0, x1_s2};

	bsc_div #(.TAG_W(TW)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2),
		.num(an), .den(ad), .in_tag(tin),
		.out_valid(dv), .quo(q), .out_tag(tout)
	);

	assign x2  = tout[34] ? -q : q;
	assign b5c = tout[31:0] + x2;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			b5     <= b5c;
			temp   <= tout[33] ? '0 : asr(b5c + 32'd8, 5'd4);
			tfault <= tout[33];
			praw_o <= tout[TW-1:35];
		end
	end
endmodule

// ===== rtl/bsc_pres.sv =====
// pressure path: b3, b4, b7, unsigned division and final correction
`timescale 1ns / 1ps
module bsc_pres import bsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  cal_t        cal,
	input  logic [31:0] b5,
	input  logic [31:0] temp,
	input  logic        tfault,
	input  logic [23:0] praw,
	output logic        out_valid,
	output logic [31:0] temp_o,
	output logic [31:0] pres_o,
	output logic        fault_o
);
	localparam int unsigned TW = 32 + 1 + 1 + 1;
	logic        v1, v2, v3, v4, v5, v6, v7;
	logic [31:0] b6_1, t_1; logic f_1; logic [31:0] up_1;
	logic [31:0] sq_2, m2_2, m3_2, t_2, up_2; logic f_2;
	logic [31:0] x1_3, x2_3, xa_3, xb_3, t_3, up_3; logic f_3;
	logic [31:0] b3_4, x3_4, t_4, up_4; logic f_4;
	logic [31:0] b4_5, d7_5, t_5; logic f_5;
	logic [31:0] b4_6, b7_6, t_6; logic f_6;
	logic [31:0] dnum;
	logic [TW-1:0] tin, tout;
	logic [31:0] q, p;
	logic        dv;
	logic [31:0] p8_8, pk_8, p_8, t_8; logic f_8, v8;
	logic [31:0] sq8_9, pk_9, p_9, t_9; logic f_9, v9;
	logic [31:0] x1_10, x2_10, p_10, t_10; logic f_10, v10;
	logic [31:0] sum10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v1, v2, v3, v4, v5, v6} <= '0;
			{v8, v9, v10, out_valid} <= '0;
		end else if (en) begin
			{v1, v2, v3, v4, v5, v6} <= {in_valid, v1, v2, v3, v4, v5};
			{v8, v9, v10, out_valid} <= {dv, v8, v9, v10};
		end
	end
	assign v7 = v6;

	always_ff @(posedge clk) begin
		if (en) begin
			// b6 and raw pressure
			b6_1 <= b5 - B6_OFFSET; t_1 <= temp; f_1 <= tfault;
			up_1 <= 32'({8'd0, praw} >> (4'd8 - {2'd0, cal.oss}));
			// products on b6
			sq_2 <= asr(b6_1 * b6_1, 5'd12);
			m2_2 <= cal.ac2 * b6_1; m3_2 <= cal.ac3 * b6_1;
			t_2 <= t_1; f_2 <= f_1; up_2 <= up_1;
			// products on sq
			x1_3 <= cal.b2 * sq_2; x2_3 <= cal.b1 * sq_2;
			xa_3 <= asr(m2_2, 5'd11); xb_3 <= asr(m3_2, 5'd13);
			t_3 <= t_2; f_3 <= f_2; up_3 <= up_2;
			// b3 and x3
			b3_4 <= asr((((cal.ac1 << 2) + asr(x1_3, 5'd11) + xa_3) << cal.oss)
				+ 32'd2, 5'd2);
			x3_4 <= asr(xb_3 + asr(x2_3, 5'd16) + 32'd2, 5'd2);
			t_4 <= t_3; f_4 <= f_3; up_4 <= up_3;
			// b4 and b7 operand
			b4_5 <= (cal.ac4 * (x3_4 + B4_BIAS)) >> 15;
			d7_5 <= up_4 - b3_4; t_5 <= t_4; f_5 <= f_4;
			b7_6 <= d7_5 * (B7_SCALE >> cal.oss);
			b4_6 <= b4_5; t_6 <= t_5; f_6 <= f_5;
		end
	end

	// b7 split keeps the unsigned range
	assign dnum = (b7_6 < B7_MSB) ? (b7_6 << 1) : b7_6;
	assign tin  = {f_6, (b4_6 == '0), (b7_6 >= B7_MSB), t_6};

	bsc_div #(.TAG_W(TW)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v7),
		.num(dnum), .den(b4_6), .in_tag(tin),
		.out_valid(dv), .quo(q), .out_tag(tout)
	);
	assign p = tout[32] ? (q << 1) : q;

	// final correction stages
	always_ff @(posedge clk) begin
		if (en) begin
			p8_8 <= asr(p, 5'd8); pk_8 <= 32'd0 - P_K2 * p; p_8 <= p;
			t_8 <= tout[31:0]; f_8 <= tout[34] | tout[33];
			sq8_9 <= p8_8 * p8_8; pk_9 <= pk_8; p_9 <= p_8;
			t_9 <= t_8; f_9 <= f_8;
			x1_10 <= asr(sq8_9 * P_K1, 5'd16); x2_10 <= asr(pk_9, 5'd16);
			p_10 <= p_9; t_10 <= t_9; f_10 <= f_9;
			temp_o  <= t_10;
			pres_o  <= f_10 ? '0 : p_10 + asr(sum10, 5'd4);
			fault_o <= f_10;
		end
	end
	assign sum10 = x1_10 + x2_10 + P_K3;
endmodule

// ===== rtl/barometric_sensor_compensation.sv =====
// top level: configuration registers, stall control and both compensation paths
`timescale 1ns / 1ps
// Takes one reading per clock while the pipeline advances and returns one result
// per reading; the result word passes through the two 32-stage restoring
// dividers (temperature, then pressure) plus register stages around them (two
// before and one after the temperature divider, six before and four after the
// pressure divider). The whole pipeline advances only while the output word is
// taken or the output is empty; a result waiting at the output holds everything
// behind it in place.
module barometric_sensor_compensation import bsc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [39:0]  s_axis_tdata,  // raw_temperature[15:0], raw_pressure_bytes[39:16]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,  // temperature_tenths[31:0], pressure_pascal[63:32]
	output logic         m_axis_tuser,  // divide_fault
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [31:0]  cfg_data
);
	logic [31:0] wa_q, wb_q, wc_q, wd_q, we_q;
	logic [1:0]  oss_q;
	cal_t        cal;
	logic        en;
	logic        tv; logic [31:0] b5, temp; logic tf; logic [23:0] praw;
	logic        pv; logic [31:0] t_o, p_o; logic f_o;

	assign cfg_ready = 1'b1;
	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{wa_q, wb_q, wc_q, wd_q, we_q} <= '0;
			oss_q <= 2'd3;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CAL_A: wa_q <= cfg_data;
				REG_CAL_B: wb_q <= cfg_data;
				REG_CAL_C: wc_q <= cfg_data;
				REG_CAL_D: wd_q <= cfg_data;
				REG_CAL_E: we_q <= cfg_data;
				REG_OSS:   oss_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign cal.ac1 = sx16(wa_q[31:16]);
	assign cal.ac2 = sx16(wa_q[15:0]);
	assign cal.ac3 = sx16(wb_q[31:16]);
	assign cal.ac4 = {16'd0, wb_q[15:0]};
	assign cal.ac5 = {16'd0, wc_q[31:16]};
	assign cal.ac6 = {16'd0, wc_q[15:0]};
	assign cal.b1  = sx16(wd_q[31:16]);
	assign cal.b2  = sx16(wd_q[15:0]);
	assign cal.mc  = sx16(we_q[31:16]);
	assign cal.md  = sx16(we_q[15:0]);
	assign cal.oss = oss_q;

	// pipeline advances when the output slot is free or drains
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	bsc_temp u_temp (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(s_axis_tvalid),
		.cal(cal), .ut(s_axis_tdata[15:0]), .praw(s_axis_tdata[39:16]),
		.out_valid(tv), .b5(b5), .temp(temp), .tfault(tf), .praw_o(praw)
	);

	bsc_pres u_pres (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(tv), .cal(cal),
		.b5(b5), .temp(temp), .tfault(tf), .praw(praw),
		.out_valid(pv), .temp_o(t_o), .pres_o(p_o), .fault_o(f_o)
	);

	assign m_axis_tvalid = pv;
	assign m_axis_tdata  = {p_o, t_o};
	assign m_axis_tuser  = f_o;
endmodule
